@@ rtl/sphere_sphere_sweep_test_macros.svh @@
// Assertion macros for the swept sphere-sphere test.
`ifndef SPHERE_SPHERE_SWEEP_TEST_MACROS_SVH
`define SPHERE_SPHERE_SWEEP_TEST_MACROS_SVH

// Same-cycle implication, off during reset.
`define SSST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssst assertion failed");

// Next-cycle implication, off during reset.
`define SSST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssst assertion failed");

`endif

@@ rtl/ssst_pkg.sv @@
// Types, widths and step functions of the swept sphere-sphere test.
`timescale 1ns / 1ps
package ssst_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 12;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int DW   = COORD_BITS + 1;     // position difference
  localparam int VW   = COORD_BITS + 2;     // relative motion
  localparam int PW   = 2 * VW;             // one product
  localparam int SW   = PW + 2;             // sum of three products
  localparam int MW   = SW;                 // magnitudes of A, |h|, C
  localparam int HALF = MW / 2;             // split point for wide products
  localparam int QW   = 2 * MW;             // h^2, A*C, discriminant
  localparam int R2W  = 2 * COORD_BITS;     // (ra+rb)^2
  localparam int SQN  = MW;                 // square-root stages, 2 bits each
  localparam int NW   = MW + 2;             // signed numerator
  localparam int CW   = MW + COORD_BITS + 1; // overflow compare width
  localparam int LAT  = SQN + COORD_BITS + 10;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_FIRST  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_SECOND = 2'd1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_start_z;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t a_end_z;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_start_z;
    coord_t b_end_x;
    coord_t b_end_y;
    coord_t b_end_z;
  } in_t;

  typedef struct packed {
    logic   hit;
    logic   overlap_at_start;
    coord_t time_first;
    coord_t time_second;
    logic   time_clamped;
  } out_t;

  typedef struct packed {
    logic ovl;       // touching at frame start
    logic az;        // no relative motion
    logic roots_ok;  // discriminant non-negative
  } flags_t;

  typedef struct packed {
    flags_t          f;
    logic [MW-1:0]   a;
    logic [MW-1:0]   hm;
    logic            hneg;
    logic [QW-1:0]   x;
    logic [MW+1:0]   rem;
    logic [MW-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic                  neg;
    logic                  ovf;
    logic [MW-1:0]         rem;
    logic [COORD_BITS-1:0] q;
    logic [COORD_BITS-1:0] low;
  } dq_t;

  typedef struct packed {
    flags_t        f;
    logic [MW-1:0] a;
    dq_t           lo;
    dq_t           hi;
  } dv_t;

  // One digit of the square root: two radicand bits in, one root bit out.
  function automatic sq_t sq_step(sq_t s);
    sq_t           r;
    logic [MW+2:0] t;
    logic [MW+2:0] trial;
    logic [MW+2:0] diff;
    r     = s;
    t     = {s.rem[MW:0], s.x[QW-1:QW-2]};
    trial = {1'b0, s.root, 2'b01};
    diff  = t - trial;
    r.x   = {s.x[QW-3:0], 2'b00};
    if (t >= trial) begin
      r.rem  = diff[MW+1:0];
      r.root = {s.root[MW-2:0], 1'b1};
    end else begin
      r.rem  = t[MW+1:0];
      r.root = {s.root[MW-2:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of the restoring division by A.
  function automatic dq_t dv_step(dq_t d, logic [MW-1:0] a);
    dq_t         r;
    logic [MW:0] t;
    logic [MW:0] diff;
    r     = d;
    t     = {d.rem, d.low[COORD_BITS-1]};
    diff  = t - {1'b0, a};
    r.low = {d.low[COORD_BITS-2:0], 1'b0};
    if (t >= {1'b0, a}) begin
      r.rem = diff[MW-1:0];
      r.q   = {d.q[COORD_BITS-2:0], 1'b1};
    end else begin
      r.rem = t[MW-1:0];
      r.q   = {d.q[COORD_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  // Scale a numerator for the divider and flag a quotient beyond range.
  function automatic dq_t dv_load(logic signed [NW-1:0] n, logic [MW-1:0] a);
    dq_t           r;
    logic [NW-1:0] mag;
    logic [CW-1:0] num;
    logic [CW-1:0] lim;
    logic [CW-1:0] hi;
    mag   = n[NW-1] ? NW'(-n) : NW'(n);
    num   = CW'(mag) << FRAC_BITS;
    lim   = CW'(a) << COORD_BITS;
    hi    = num >> COORD_BITS;
    r.neg = n[NW-1];
    r.ovf = num >= lim;
    r.rem = hi[MW-1:0];
    r.q   = '0;
    r.low = num[COORD_BITS-1:0];
    return r;
  endfunction

endpackage

@@ rtl/sphere_sphere_sweep_test.sv @@
// Swept sphere-sphere collision test, fully pipelined.
`timescale 1ns / 1ps
`include "sphere_sphere_sweep_test_macros.svh"

// One sphere pair enters per cycle (busy stays low); its result passes the
// front stages, root chain, divider chain and output register, one strobe on
// out_valid per item, in order. The depth is set by the square-root pipeline
// (one root bit per stage over the discriminant) and the two parallel
// restoring dividers (one time bit per stage). The receiver cannot stall: a
// result is on out_data for the single cycle of its strobe. The user must
// write radii through cfg_* only while no item is in flight; no logic stops it.
module sphere_sphere_sweep_test
  import ssst_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  in_t                     in_data,
  output logic                    out_valid,
  output out_t                    out_data,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [RAD_BITS-1:0]     cfg_wdata
);

  // radius registers
  logic [RAD_BITS-1:0] rad_a_r, rad_b_r;

  // valid bits, one per stage
  logic [LAT-1:0] vld_r, vld_nxt;

  // stage 1: relative motion v and start offset d0
  logic signed [VW-1:0] v1_r[3], v1_nxt[3];
  logic signed [DW-1:0] d1_r[3], d1_nxt[3];
  // stage 2: products
  logic signed [PW-1:0] vv2_r[3], vd2_r[3], dd2_r[3];
  logic signed [PW-1:0] vv2_nxt[3], vd2_nxt[3], dd2_nxt[3];
  logic [R2W-1:0]       r2_2_r, r2_2_nxt;
  // stage 3: dot products
  logic signed [SW-1:0] a3_r, h3_r, dd3_r, a3_nxt, h3_nxt, dd3_nxt;
  logic [R2W-1:0]       r2_3_r;
  // stage 4: magnitudes, start overlap
  logic [MW-1:0]        a4_r, hm4_r, c4_r, a4_nxt, hm4_nxt, c4_nxt;
  logic                 hneg4_r, ovl4_r, az4_r, hneg4_nxt, ovl4_nxt, az4_nxt;
  // stage 5: partial products of h^2 and A*C
  logic [MW-1:0]        phh5_r, phl5_r, pll5_r, phh5_nxt, phl5_nxt, pll5_nxt;
  logic [MW-1:0]        qhh5_r, qhl5_r, qlh5_r, qll5_r;
  logic [MW-1:0]        qhh5_nxt, qhl5_nxt, qlh5_nxt, qll5_nxt;
  logic [MW-1:0]        a5_r, hm5_r;
  logic                 hneg5_r, ovl5_r, az5_r;
  // stage 6: full h^2 and A*C
  logic [QW-1:0]        h2_6_r, ac6_r, h2_6_nxt, ac6_nxt;
  logic [MW-1:0]        a6_r, hm6_r;
  logic                 hneg6_r, ovl6_r, az6_r;
  // square root chain, entry 0 holds the discriminant
  sq_t                  sq_r[SQN+1], sq_nxt[SQN+1];
  // numerators -h - s and -h + s
  logic signed [NW-1:0] nlo_r, nhi_r, nlo_nxt, nhi_nxt;
  flags_t               nf_r;
  logic [MW-1:0]        na_r;
  // divider chain, entry 0 holds the loaded numerators
  dv_t                  dv_r[COORD_BITS+1], dv_nxt[COORD_BITS+1];
  // output register
  out_t                 out_r, out_nxt;

  coord_t               ax_s[3], ax_e[3], bx_s[3], bx_e[3];

  assign busy      = 1'b0;          // takes an item every cycle
  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

  assign ax_s = '{in_data.a_start_x, in_data.a_start_y, in_data.a_start_z};
  assign ax_e = '{in_data.a_end_x,   in_data.a_end_y,   in_data.a_end_z};
  assign bx_s = '{in_data.b_start_x, in_data.b_start_y, in_data.b_start_z};
  assign bx_e = '{in_data.b_end_x,   in_data.b_end_y,   in_data.b_end_z};

  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  // stage 1: v = (Be - Bs) - (Ae - As), d0 = Bs - As
  always_comb begin
    logic signed [DW-1:0] va, vb;
    for (int i = 0; i < 3; i++) begin
      va        = DW'(ax_e[i]) - DW'(ax_s[i]);
      vb        = DW'(bx_e[i]) - DW'(bx_s[i]);
      v1_nxt[i] = VW'(vb) - VW'(va);
      d1_nxt[i] = DW'(bx_s[i]) - DW'(ax_s[i]);
    end
  end

  // stage 2: per-axis products and (ra+rb)^2
  always_comb begin
    logic [COORD_BITS-1:0] rsum;
    for (int i = 0; i < 3; i++) begin
      vv2_nxt[i] = PW'(v1_r[i]) * PW'(v1_r[i]);
      vd2_nxt[i] = PW'(v1_r[i]) * PW'(d1_r[i]);
      dd2_nxt[i] = PW'(d1_r[i]) * PW'(d1_r[i]);
    end
    rsum     = COORD_BITS'(rad_a_r) + COORD_BITS'(rad_b_r);
    r2_2_nxt = R2W'(rsum) * R2W'(rsum);
  end

  // stage 3: A = v.v, h = v.d0, |d0|^2
  always_comb begin
    a3_nxt  = SW'(vv2_r[0]) + SW'(vv2_r[1]) + SW'(vv2_r[2]);
    h3_nxt  = SW'(vd2_r[0]) + SW'(vd2_r[1]) + SW'(vd2_r[2]);
    dd3_nxt = SW'(dd2_r[0]) + SW'(dd2_r[1]) + SW'(dd2_r[2]);
  end

  // stage 4: start overlap test, C = |d0|^2 - r^2, |h|
  always_comb begin
    logic signed [SW-1:0] r2e;
    logic signed [SW-1:0] cd;
    r2e       = $signed(SW'(r2_3_r));
    cd        = dd3_r - r2e;
    ovl4_nxt  = dd3_r <= r2e;
    c4_nxt    = MW'(cd);
    a4_nxt    = MW'(a3_r);
    az4_nxt   = a3_r == '0;
    hneg4_nxt = h3_r[SW-1];
    hm4_nxt   = h3_r[SW-1] ? MW'(-h3_r) : MW'(h3_r);
  end

  // stage 5: half-width partial products
  always_comb begin
    logic [HALF-1:0] hh, hl, ah, al, ch, cl;
    hh       = hm4_r[MW-1:HALF];
    hl       = hm4_r[HALF-1:0];
    ah       = a4_r[MW-1:HALF];
    al       = a4_r[HALF-1:0];
    ch       = c4_r[MW-1:HALF];
    cl       = c4_r[HALF-1:0];
    phh5_nxt = MW'(hh) * MW'(hh);
    phl5_nxt = MW'(hh) * MW'(hl);
    pll5_nxt = MW'(hl) * MW'(hl);
    qhh5_nxt = MW'(ah) * MW'(ch);
    qhl5_nxt = MW'(ah) * MW'(cl);
    qlh5_nxt = MW'(al) * MW'(ch);
    qll5_nxt = MW'(al) * MW'(cl);
  end

  // stage 6: recombine
  always_comb begin
    h2_6_nxt = (QW'(phh5_r) << (2 * HALF)) + (QW'(phl5_r) << (HALF + 1))
             + QW'(pll5_r);
    ac6_nxt  = (QW'(qhh5_r) << (2 * HALF))
             + ((QW'(qhl5_r) + QW'(qlh5_r)) << HALF) + QW'(qll5_r);
  end

  // stage 7 and the root chain
  always_comb begin
    sq_nxt[0].f.ovl      = ovl6_r;
    sq_nxt[0].f.az       = az6_r;
    sq_nxt[0].f.roots_ok = h2_6_r >= ac6_r;
    sq_nxt[0].a          = a6_r;
    sq_nxt[0].hm         = hm6_r;
    sq_nxt[0].hneg       = hneg6_r;
    sq_nxt[0].x          = h2_6_r - ac6_r;
    sq_nxt[0].rem        = '0;
    sq_nxt[0].root       = '0;
    for (int k = 1; k <= SQN; k++) begin
      sq_nxt[k] = sq_step(sq_r[k-1]);
    end
  end

  // numerators: -h -/+ floor(sqrt(disc))
  always_comb begin
    logic signed [NW-1:0] mh, s;
    mh      = sq_r[SQN].hneg ? $signed(NW'(sq_r[SQN].hm)) : -$signed(NW'(sq_r[SQN].hm));
    s       = $signed(NW'(sq_r[SQN].root));
    nlo_nxt = mh - s;
    nhi_nxt = mh + s;
  end

  // divider chain
  always_comb begin
    dv_nxt[0].f  = nf_r;
    dv_nxt[0].a  = na_r;
    dv_nxt[0].lo = dv_load(nlo_r, na_r);
    dv_nxt[0].hi = dv_load(nhi_r, na_r);
    for (int k = 1; k <= COORD_BITS; k++) begin
      dv_nxt[k]    = dv_r[k-1];
      dv_nxt[k].lo = dv_step(dv_r[k-1].lo, dv_r[k-1].a);
      dv_nxt[k].hi = dv_step(dv_r[k-1].hi, dv_r[k-1].a);
    end
  end

  // saturate the two times and build the result
  always_comb begin
    dv_t                   d;
    logic [COORD_BITS-1:0] lim_lo, lim_hi, m_lo, m_hi;
    logic                  c_lo, c_hi;
    d      = dv_r[COORD_BITS];
    lim_lo = d.lo.neg ? COORD_BITS'(1) << (COORD_BITS - 1)
                      : (COORD_BITS'(1) << (COORD_BITS - 1)) - 1'b1;
    lim_hi = d.hi.neg ? COORD_BITS'(1) << (COORD_BITS - 1)
                      : (COORD_BITS'(1) << (COORD_BITS - 1)) - 1'b1;
    c_lo   = d.lo.ovf | (d.lo.q > lim_lo);
    c_hi   = d.hi.ovf | (d.hi.q > lim_hi);
    m_lo   = c_lo ? lim_lo : d.lo.q;
    m_hi   = c_hi ? lim_hi : d.hi.q;
    out_nxt = '0;
    if (d.f.ovl) begin
      out_nxt.hit              = 1'b1;
      out_nxt.overlap_at_start = 1'b1;
    end else if (!d.f.az && d.f.roots_ok) begin
      out_nxt.hit          = 1'b1;
      out_nxt.time_first   = d.lo.neg ? -$signed(m_lo) : $signed(m_lo);
      out_nxt.time_second  = d.hi.neg ? -$signed(m_hi) : $signed(m_hi);
      out_nxt.time_clamped = c_lo | c_hi;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rad_a_r <= '0;
      rad_b_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIUS_FIRST:  rad_a_r <= cfg_wdata;
          REG_RADIUS_SECOND: rad_b_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // datapath, advances every cycle
  always_ff @(posedge clk) begin
    v1_r    <= v1_nxt;
    d1_r    <= d1_nxt;
    vv2_r   <= vv2_nxt;
    vd2_r   <= vd2_nxt;
    dd2_r   <= dd2_nxt;
    r2_2_r  <= r2_2_nxt;
    a3_r    <= a3_nxt;
    h3_r    <= h3_nxt;
    dd3_r   <= dd3_nxt;
    r2_3_r  <= r2_2_r;
    a4_r    <= a4_nxt;
    hm4_r   <= hm4_nxt;
    c4_r    <= c4_nxt;
    hneg4_r <= hneg4_nxt;
    ovl4_r  <= ovl4_nxt;
    az4_r   <= az4_nxt;
    phh5_r  <= phh5_nxt;
    phl5_r  <= phl5_nxt;
    pll5_r  <= pll5_nxt;
    qhh5_r  <= qhh5_nxt;
    qhl5_r  <= qhl5_nxt;
    qlh5_r  <= qlh5_nxt;
    qll5_r  <= qll5_nxt;
    a5_r    <= a4_r;
    hm5_r   <= hm4_r;
    hneg5_r <= hneg4_r;
    ovl5_r  <= ovl4_r;
    az5_r   <= az4_r;
    h2_6_r  <= h2_6_nxt;
    ac6_r   <= ac6_nxt;
    a6_r    <= a5_r;
    hm6_r   <= hm5_r;
    hneg6_r <= hneg5_r;
    ovl6_r  <= ovl5_r;
    az6_r   <= az5_r;
    sq_r    <= sq_nxt;
    nlo_r   <= nlo_nxt;
    nhi_r   <= nhi_nxt;
    nf_r    <= sq_r[SQN].f;
    na_r    <= sq_r[SQN].a;
    dv_r    <= dv_nxt;
    out_r   <= out_nxt;
  end

  `SSST_ASSERT_NXT(a_latency, start && !busy, ##(LAT-1) out_valid)
  `SSST_ASSERT_IMP(a_no_ghost, out_valid, $past(start && !busy, LAT))
  `SSST_ASSERT_IMP(a_ovl_hit, out_valid && out_data.overlap_at_start, out_data.hit && out_data.time_first == 0 && out_data.time_second == 0)
  `SSST_ASSERT_IMP(a_miss_zero, out_valid && !out_data.hit, out_data.time_first == 0 && out_data.time_second == 0 && !out_data.time_clamped)
  `SSST_ASSERT_IMP(a_order, out_valid, out_data.time_first <= out_data.time_second)
  `SSST_ASSERT_IMP(a_cfg_idle, cfg_we, vld_r == '0)

endmodule
